FILE: src/abvts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the A/B variation trigger sequencer.
// No dependencies; used by the channel interfaces and the top level.
package abvts_pkg;

  // Field widths of the configuration registers.
  localparam int PatW   = 16;
  localparam int LenW   = 5;
  localparam int RepW   = 4;
  localparam int HoldW  = 24;

  // Configuration channel widths.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 24;

  // Register indexes on the configuration channel.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_A      = 3'd0,
    CFG_PATTERN_B      = 3'd1,
    CFG_SEQ_LENGTH     = 3'd2,
    CFG_MAX_REPEATS    = 3'd3,
    CFG_LED_HOLD_TICKS = 3'd4
  } cfg_idx_t;

  // Register reset values.
  localparam logic [LenW-1:0]  SeqLengthRst  = 5'd8;
  localparam logic [RepW-1:0]  MaxRepeatsRst = 4'd8;
  localparam logic [HoldW-1:0] LedHoldRst    = 24'd90000;

  // Repeat count saturates here; LED counter saturates at all ones.
  localparam logic [RepW-1:0]  RepeatSat = 4'd15;
  localparam logic [HoldW-1:0] LedSat    = {HoldW{1'b1}};

endpackage

FILE: src/abvts_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the trigger sequencer:
// clock level input, gate/LED result and configuration write channel.
// Depends on abvts_pkg for widths.
interface abvts_in_if;
  logic valid;
  logic ready;
  logic clock_in;

  modport source (output valid, output clock_in, input ready);
  modport sink   (input valid, input clock_in, output ready);
endinterface

interface abvts_out_if;
  logic valid;
  logic ready;
  logic gate_out;
  logic reset_led;

  modport source (output valid, output gate_out, output reset_led, input ready);
  modport sink   (input valid, input gate_out, input reset_led, output ready);
endinterface

interface abvts_cfg_if import abvts_pkg::*;;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/ab_variation_trigger_sequencer_top.sv
`timescale 1ns / 1ps
// Top level of the A/B variation trigger sequencer.
// Depends on abvts_pkg and the channel interfaces in abvts_ifs.sv.

// One beat on the input channel is one sampled level of the external clock
// and yields exactly one result beat carrying the gate level and the reset
// LED. The sequencer state and the result register both update at the
// accepting edge, so a new beat is taken each cycle while the result
// register is empty or being drained. A rising level fires the current
// step of the active pattern and advances it; after max_repeats-1 passes
// of pattern A, pattern B plays one pass, then the LED lights for
// led_hold_ticks beats. Configuration writes are always accepted and take
// effect on the next input beat; indexes beyond the register list are
// ignored.
module ab_variation_trigger_sequencer_top
  import abvts_pkg::*;
#(
  parameter int MAX_STEPS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  abvts_in_if.sink      in_bus,
  abvts_out_if.source   out_bus,
  abvts_cfg_if.sink     cfg_bus
);

  localparam int SIW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW  = (SIW + 1 > LenW) ? SIW + 1 : LenW;
  localparam logic [CW-1:0] MaxStepsC = CW'(MAX_STEPS);
  localparam logic [CW-1:0] OneC      = CW'(1);

  // Configuration registers.
  logic [PatW-1:0]  pattern_a_r, pattern_b_r;
  logic [LenW-1:0]  seq_length_r;
  logic [RepW-1:0]  max_repeats_r;
  logic [HoldW-1:0] led_hold_r;

  // Sequencer state.
  logic [SIW-1:0]   step_index_r, step_index_nxt;
  logic [RepW-1:0]  repeat_count_r, repeat_count_nxt;
  logic             playing_b_r, playing_b_nxt;
  logic             edge_seen_r, edge_seen_nxt;
  logic             led_active_r, led_active_nxt;
  logic [HoldW-1:0] led_counter_r, led_counter_nxt;
  logic             gate_level_r, gate_level_nxt;

  // Result register.
  logic             out_valid_r;
  logic             gate_out_r, reset_led_r;
  logic             led_out;

  logic             in_fire;
  logic             cfg_fire;

  logic [PatW-1:0]  pat_sel;
  logic [PatW-1:0]  pat_shift;
  logic [CW-1:0]    len_eff;
  logic [CW-1:0]    step_inc;
  logic [HoldW-1:0] led_inc;
  logic [RepW-1:0]  rep_inc;

  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready = 1'b1;
  assign cfg_fire      = cfg_bus.valid;

  assign out_bus.valid     = out_valid_r;
  assign out_bus.gate_out  = gate_out_r;
  assign out_bus.reset_led = reset_led_r;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_a_r   <= '0;
      pattern_b_r   <= '0;
      seq_length_r  <= SeqLengthRst;
      max_repeats_r <= MaxRepeatsRst;
      led_hold_r    <= LedHoldRst;
    end else if (cfg_fire) begin
      unique case (cfg_bus.index)
        CFG_PATTERN_A:      pattern_a_r   <= cfg_bus.data[PatW-1:0];
        CFG_PATTERN_B:      pattern_b_r   <= cfg_bus.data[PatW-1:0];
        CFG_SEQ_LENGTH:     seq_length_r  <= cfg_bus.data[LenW-1:0];
        CFG_MAX_REPEATS:    max_repeats_r <= cfg_bus.data[RepW-1:0];
        CFG_LED_HOLD_TICKS: led_hold_r    <= cfg_bus.data[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Effective pass length, clamped to one step at the low end and
  // MAX_STEPS at the high end.
  always_comb begin
    len_eff = CW'(seq_length_r);
    if (len_eff == '0) begin
      len_eff = OneC;
    end else if (len_eff > MaxStepsC) begin
      len_eff = MaxStepsC;
    end
  end

  // Step bit of the active pattern; steps beyond the pattern read zero.
  assign pat_sel   = playing_b_r ? pattern_b_r : pattern_a_r;
  assign pat_shift = pat_sel >> step_index_r;
  assign step_inc  = CW'(step_index_r) + OneC;
  assign led_inc   = (led_counter_r == LedSat) ? led_counter_r : led_counter_r + 1'b1;
  assign rep_inc   = (repeat_count_r < RepeatSat) ? repeat_count_r + 1'b1 : repeat_count_r;

  // Next state for one beat: LED timing first, then the clock level.
  always_comb begin
    step_index_nxt   = step_index_r;
    repeat_count_nxt = repeat_count_r;
    playing_b_nxt    = playing_b_r;
    edge_seen_nxt    = edge_seen_r;
    led_active_nxt   = led_active_r;
    led_counter_nxt  = led_counter_r;
    gate_level_nxt   = gate_level_r;
    led_out          = 1'b0;

    if (led_active_r) begin
      if (led_inc > led_hold_r || led_inc == LedSat) begin
        led_counter_nxt = '0;
        led_active_nxt  = 1'b0;
      end else begin
        led_counter_nxt = led_inc;
        led_out         = 1'b1;
      end
    end

    if (in_bus.clock_in) begin
      if (!edge_seen_r) begin
        if (pat_shift[0]) begin
          gate_level_nxt = 1'b0;
        end
        edge_seen_nxt = 1'b1;
        if (step_inc >= len_eff) begin
          step_index_nxt = '0;
          // End of a pass.
          if (!playing_b_r) begin
            repeat_count_nxt = rep_inc;
            if (max_repeats_r != '0 && rep_inc == max_repeats_r - 1'b1) begin
              playing_b_nxt = 1'b1;
            end
          end else begin
            playing_b_nxt    = 1'b0;
            repeat_count_nxt = '0;
            led_active_nxt   = 1'b1;
          end
        end else begin
          step_index_nxt = step_inc[SIW-1:0];
        end
      end
    end else begin
      edge_seen_nxt  = 1'b0;
      gate_level_nxt = 1'b1;
    end
  end

  // State and result registers advance on an accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_index_r   <= '0;
      repeat_count_r <= '0;
      playing_b_r    <= 1'b0;
      edge_seen_r    <= 1'b0;
      led_active_r   <= 1'b0;
      led_counter_r  <= '0;
      gate_level_r   <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        step_index_r   <= step_index_nxt;
        repeat_count_r <= repeat_count_nxt;
        playing_b_r    <= playing_b_nxt;
        edge_seen_r    <= edge_seen_nxt;
        led_active_r   <= led_active_nxt;
        led_counter_r  <= led_counter_nxt;
        gate_level_r   <= gate_level_nxt;
        out_valid_r    <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      gate_out_r  <= gate_level_nxt;
      reset_led_r <= led_out;
    end
  end

  // Step index never leaves the pattern range.
  assert property (@(posedge clk) disable iff (!rst_n)
    CW'(step_index_r) < MaxStepsC)
    else $error("step index out of range");

  // The gate is only low while a rising level is being held.
  assert property (@(posedge clk) disable iff (!rst_n)
    !gate_level_r |-> edge_seen_r)
    else $error("gate low without a seen edge");

  // Pattern B only plays after at least one pass of A.
  assert property (@(posedge clk) disable iff (!rst_n)
    playing_b_r |-> repeat_count_r != '0)
    else $error("pattern B active with zero repeat count");

  // The LED counter rests at zero while the LED is dark.
  assert property (@(posedge clk) disable iff (!rst_n)
    !led_active_r |-> led_counter_r == '0)
    else $error("LED counter running while LED inactive");

  // Every accepted beat leaves a result waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted beat produced no result");

endmodule

FILE: verif/tb_ab_variation_trigger_sequencer_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the A/B variation trigger sequencer top level.
// Depends on abvts_pkg and the channel interfaces in abvts_ifs.sv.
module tb_ab_variation_trigger_sequencer_top;
  import abvts_pkg::*;

  localparam int MaxSteps     = 16;
  localparam int StallLimit   = 2000;
  localparam int SettleCycles = 8;
  localparam int ReportLimit  = 40;
  localparam logic [CfgIdxW-1:0] CfgIdxLast = CFG_LED_HOLD_TICKS;

  // Directed clock levels, sent most significant bit first.
  localparam logic [11:0] PassLevels   = 12'b1101_0010_1000;
  localparam logic [9:0]  SingleLevels = 10'b10_1101_0011;

  logic clk;
  logic rst_n;

  abvts_in_if  in_if ();
  abvts_out_if out_if ();
  abvts_cfg_if cfg_if ();

  ab_variation_trigger_sequencer_top #(
    .MAX_STEPS(MaxSteps)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_if.sink),
    .out_bus(out_if.source),
    .cfg_bus(cfg_if.sink)
  );

  typedef struct packed {
    logic gate;
    logic led;
  } gate_led_t;

  // Tracks the sequencer state, predicts the gate and LED levels of every
  // accepted clock level and checks them against the result beats.
  class gate_led_scoreboard;
    logic [PatW-1:0]  pat_a;
    logic [PatW-1:0]  pat_b;
    logic [LenW-1:0]  seq_len;
    logic [RepW-1:0]  max_rep;
    logic [HoldW-1:0] hold;
    logic [LenW-1:0]  step;
    logic [RepW-1:0]  passes;
    logic             on_b;
    logic             high_seen;
    logic             led_on;
    logic [HoldW-1:0] led_cnt;
    logic             gate_lvl;
    gate_led_t        pending_levels[$];
    int               errors;
    int               beats;

    function void clear();
      pat_a     = '0;
      pat_b     = '0;
      seq_len   = SeqLengthRst;
      max_rep   = MaxRepeatsRst;
      hold      = LedHoldRst;
      step      = '0;
      passes    = '0;
      on_b      = 1'b0;
      high_seen = 1'b0;
      led_on    = 1'b0;
      led_cnt   = '0;
      gate_lvl  = 1'b1;
      pending_levels.delete();
      errors    = 0;
      beats     = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_PATTERN_A:      pat_a   = data[PatW-1:0];
        CFG_PATTERN_B:      pat_b   = data[PatW-1:0];
        CFG_SEQ_LENGTH:     seq_len = data[LenW-1:0];
        CFG_MAX_REPEATS:    max_rep = data[RepW-1:0];
        CFG_LED_HOLD_TICKS: hold    = data[HoldW-1:0];
        default: ;
      endcase
    endfunction

    // A zero length plays one step; lengths past the pattern size are clipped.
    function int unsigned pass_length();
      int unsigned n;
      n = seq_len;
      if (n == 0) n = 1;
      if (n > MaxSteps) n = MaxSteps;
      return n;
    endfunction

    // A pass of A counts toward the variation; a pass of B lights the LED.
    function void close_pass();
      if (!on_b) begin
        if (passes < RepeatSat) passes = passes + 1'b1;
        if (max_rep >= 1 && passes == max_rep - 1) on_b = 1'b1;
      end else begin
        on_b   = 1'b0;
        passes = '0;
        led_on = 1'b1;
      end
    endfunction

    function void note_level(logic lvl);
      gate_led_t       res;
      logic [PatW-1:0] pat;
      res.led = 1'b0;
      // LED hold timing comes first within a tick.
      if (led_on) begin
        if (led_cnt != LedSat) led_cnt = led_cnt + 1'b1;
        if (led_cnt > hold || led_cnt == LedSat) begin
          led_cnt = '0;
          led_on  = 1'b0;
        end else begin
          res.led = 1'b1;
        end
      end
      // A rising level fires the current step and advances it.
      if (lvl) begin
        if (!high_seen) begin
          pat = on_b ? pat_b : pat_a;
          if (step < 16 && pat[step[3:0]]) gate_lvl = 1'b0;
          step = step + 1'b1;
          if (step >= pass_length()) begin
            step = '0;
            close_pass();
          end
          high_seen = 1'b1;
        end
      end else begin
        high_seen = 1'b0;
        gate_lvl  = 1'b1;
      end
      res.gate = gate_lvl;
      pending_levels.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= ReportLimit) $display("mismatch at result beat %0d: %s", beats, msg);
    endtask

    task check_beat(logic gate, logic led);
      gate_led_t want;
      if (pending_levels.size() == 0) begin
        report("result beat with no clock level pending");
      end else begin
        want = pending_levels.pop_front();
        if (gate !== want.gate)
          report($sformatf("gate_out %b, expected %b", gate, want.gate));
        if (led !== want.led)
          report($sformatf("reset_led %b, expected %b", led, want.led));
      end
      beats++;
    endtask
  endclass

  gate_led_scoreboard sb;
  int send_idle_pct;
  int recv_idle_pct;
  int levels_sent;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random on every falling edge.
  always @(negedge clk) begin
    out_if.ready = ($urandom_range(99) >= recv_idle_pct);
  end

  // Every beat on any channel is seen here at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) sb.check_beat(out_if.gate_out, out_if.reset_led);
      if (in_if.valid && in_if.ready) sb.note_level(in_if.clock_in);
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
    end
  end

  // Ends the run when no channel has moved a beat for too long.
  initial begin : watchdog
    int stalled;
    stalled = 0;
    while (stalled < StallLimit) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready) || !rst_n)
        stalled = 0;
      else
        stalled++;
    end
    $display("FAILURE");
    $finish;
  end

  // Sends one clock level; valid stays high after the beat until the next
  // falling edge decides on a gap or the next level.
  task automatic send_level(logic lvl);
    if (levels_sent < 517) begin
      send_idle_pct = 38;
      recv_idle_pct = 61;
    end else if (levels_sent < 1034) begin
      send_idle_pct = 61;
      recv_idle_pct = 38;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid    = 1'b1;
    in_if.clock_in = lvl;
    do @(posedge clk); while (!in_if.ready);
    levels_sent++;
  endtask

  // Holds the sender off until every pending result has come back.
  task automatic drain();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(logic [CfgDataW-1:0] pa, logic [CfgDataW-1:0] pb,
                           logic [CfgDataW-1:0] len, logic [CfgDataW-1:0] rep,
                           logic [CfgDataW-1:0] hold);
    drain();
    cfg_write(CFG_PATTERN_A, pa);
    cfg_write(CFG_PATTERN_B, pb);
    cfg_write(CFG_SEQ_LENGTH, len);
    cfg_write(CFG_MAX_REPEATS, rep);
    cfg_write(CFG_LED_HOLD_TICKS, hold);
  endtask

  // Mostly clean clock runs of one to three beats per level, with some
  // single random levels mixed in as glitches.
  task automatic drive_levels(int n);
    int   sent;
    int   run;
    logic lvl;
    sent = 0;
    lvl  = 1'b1;
    while (sent < n) begin
      if ($urandom_range(9) < 2) begin
        send_level(1'($urandom_range(1)));
        sent++;
      end else begin
        run = $urandom_range(1, 3);
        repeat (run) begin
          send_level(lvl);
          sent++;
        end
        lvl = ~lvl;
      end
    end
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] pa, logic [CfgDataW-1:0] pb,
                           logic [CfgDataW-1:0] len, logic [CfgDataW-1:0] rep,
                           logic [CfgDataW-1:0] hold, int n);
    configure(pa, pb, len, rep, hold);
    drive_levels(n);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.clock_in = 1'b0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_PATTERN_A;
    cfg_if.data    = '0;
    send_idle_pct  = 38;
    recv_idle_pct  = 61;
    levels_sent    = 0;
    sb = new();
    sb.clear();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // One-step passes: A fires, B plays after one pass, then a short LED hold.
    // The first level is high straight after reset.
    configure(24'h00FFFF, 24'h000001, 24'd1, 24'd2, 24'd1);
    for (int i = 11; i >= 0; i--) send_level(PassLevels[i]);

    // Zero length acts as one step; a single repeat never plays B.
    configure(24'h008000, 24'h00FFFF, 24'd0, 24'd1, 24'hFFFFFE);
    for (int i = 9; i >= 0; i--) send_level(SingleLevels[i]);

    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd4, 24'd3,
              24'd3, 150);
    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd16, 24'd2,
              24'($urandom_range(1, 40)), 250);
    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd1, 24'd1,
              24'hFFFFFE, 120);
    // Length past the pattern size, then the largest repeat count.
    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd31, 24'd2,
              24'($urandom_range(1, 40)), 200);
    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd1, 24'd15,
              24'd5, 150);
    // Zero repeats: the pass count saturates and B never plays, even after
    // the repeat limit is raised again below.
    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd0, 24'd0,
              24'd2, 100);
    run_phase(24'($urandom_range(16'hFFFF)), 24'($urandom_range(16'hFFFF)), 24'd2, 24'd8,
              24'd0, 150);
    run_phase(24'h00FFFF, 24'h000000, 24'($urandom_range(1, 16)), 24'($urandom_range(1, 8)),
              24'hFFFFFF, 150);

    // Full-width random register values, and writes to unused indexes.
    run_phase(24'($urandom()), 24'($urandom()), 24'($urandom()), 24'($urandom()),
              24'($urandom_range(0, 60)), 130);
    drain();
    for (int k = 1; k <= 3; k++) cfg_write(CfgIdxW'(CfgIdxLast + k), 24'($urandom()));
    run_phase(24'($urandom()), 24'($urandom()), 24'($urandom_range(1, 16)),
              24'($urandom_range(1, 4)), 24'($urandom()), 130);

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending_levels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
src/abvts_pkg.sv
src/abvts_ifs.sv
src/ab_variation_trigger_sequencer_top.sv
verif/tb_ab_variation_trigger_sequencer_top.sv
